### rtl/core/cbm_pkg.sv
`timescale 1ns / 1ps
// cbm_pkg: shared types and constants of the cartridge bank mapper
// no dependencies

package cbm_pkg;

    localparam int ROM_ADDR_BITS_DEF = 21;
    localparam int PHYS_ADDR_BITS    = 21;
    localparam int BUS_ADDR_BITS     = 16;

    // controller kinds, kind 3 behaves as no controller
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC2 = 2'd2;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_CTRL = 2'd3
    } t_target;

endpackage

### rtl/core/cbm_if.sv
`timescale 1ns / 1ps
// cbm_req_if / cbm_rsp_if: valid-ready channels of the bank mapper
// depends on cbm_pkg

interface cbm_req_if import cbm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [BUS_ADDR_BITS-1:0] bus_address;
    logic [7:0]               write_data;

    modport source (output valid, operation, bus_address, write_data, input ready);
    modport sink   (input valid, operation, bus_address, write_data, output ready);
endinterface

interface cbm_rsp_if import cbm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                target;
    logic [PHYS_ADDR_BITS-1:0] physical_address;
    logic                      ram_write_strobe;

    modport source (output valid, target, physical_address, ram_write_strobe, input ready);
    modport sink   (input valid, target, physical_address, ram_write_strobe, output ready);
endinterface

### rtl/core/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// cartridge_bank_mapper: MBC1/MBC2 style ROM/RAM bank mapping of CPU bus accesses
// each access is registered in the input register, mapped, then held in the result register
// throughput: one access per cycle while the result side is ready, set by the single mapping stage
// synchronous active-low reset: pipeline empty, controller kind MBC1, RAM disabled,
// low bank 1, upper bits 0, ROM banking mode; depends on cbm_pkg and cbm_if

module cartridge_bank_mapper import cbm_pkg::*; #(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF   // 15..21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    cbm_req_if.sink          i_req,
    cbm_rsp_if.source        o_rsp
);

    // mask applied to every ROM address
    localparam logic [PHYS_ADDR_BITS-1:0] ROM_MASK =
        PHYS_ADDR_BITS'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    // configuration and banking state
    logic [1:0] r_kind;
    logic       r_ram_en,   n_ram_en;
    logic [4:0] r_low_bank, n_low_bank;
    logic [1:0] r_up_bank,  n_up_bank;
    logic       r_mode,     n_mode;

    // input register stage
    logic                     r_s1_valid;
    logic                     r_s1_op;
    logic [BUS_ADDR_BITS-1:0] r_s1_addr;
    logic [7:0]               r_s1_data;

    // result register
    logic                      r_out_valid;
    t_target                   r_out_target, n_out_target;
    logic [PHYS_ADDR_BITS-1:0] r_out_addr,   n_out_addr;
    logic                      r_out_strobe, n_out_strobe;

    logic s1_adv;   // input register may load
    logic s2_adv;   // mapping stage may move into the result register

    // a stage moves when the one after it is empty or drains in the same cycle
    assign s2_adv      = !r_out_valid || o_rsp.ready;
    assign s1_adv      = !r_s1_valid || s2_adv;
    assign i_req.ready = s1_adv;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.target           = r_out_target;
    assign o_rsp.physical_address = r_out_addr;
    assign o_rsp.ram_write_strobe = r_out_strobe;

    // mapping logic on the registered access
    logic       is_mbc1, is_mbc2, has_ctrl;
    logic       in_rom, in_ram;
    logic [6:0] rom_bank;
    logic [3:0] mbc2_bank;
    logic [1:0] ram_bank;

    always_comb begin
        is_mbc1  = (r_kind == KIND_MBC1);
        is_mbc2  = (r_kind == KIND_MBC2);
        has_ctrl = is_mbc1 || is_mbc2;
        in_rom   = !r_s1_addr[15];
        in_ram   = (r_s1_addr[15:13] == 3'b101);

        // MBC2 never selects bank 0 in the switchable window
        mbc2_bank = (r_low_bank[3:0] == 4'd0) ? 4'd1 : r_low_bank[3:0];

        // ROM bank: lower window fixed unless MBC1 in RAM banking mode
        if (is_mbc1) begin
            if (!r_s1_addr[14]) begin
                rom_bank = r_mode ? {r_up_bank, 5'd0} : 7'd0;
            end else begin
                rom_bank = {r_up_bank, r_low_bank};
            end
        end else begin
            rom_bank = r_s1_addr[14] ? {3'd0, mbc2_bank} : 7'd0;
        end

        ram_bank = r_mode ? r_up_bank : 2'd0;

        n_out_target = TGT_NONE;
        n_out_addr   = '0;
        n_out_strobe = 1'b0;
        n_ram_en     = r_ram_en;
        n_low_bank   = r_low_bank;
        n_up_bank    = r_up_bank;
        n_mode       = r_mode;

        if (in_rom) begin
            if (r_s1_op) begin
                // control register write, decoded per controller kind
                n_out_target = TGT_CTRL;
                if (is_mbc1) begin
                    unique case (r_s1_addr[14:13])
                        2'd0: n_ram_en = (r_s1_data[3:0] == RAM_ENABLE_KEY);
                        2'd1: n_low_bank = (r_s1_data[4:0] == 5'd0) ? 5'd1 : r_s1_data[4:0];
                        2'd2: n_up_bank = r_s1_data[1:0];
                        2'd3: n_mode = r_s1_data[0];
                    endcase
                end else if (is_mbc2 && !r_s1_addr[14]) begin
                    // address bit 8 picks RAM enable or ROM bank
                    if (!r_s1_addr[8]) begin
                        n_ram_en = (r_s1_data[3:0] == RAM_ENABLE_KEY);
                    end else begin
                        n_low_bank = (r_s1_data[3:0] == 4'd0) ? 5'd1
                                                               : {1'b0, r_s1_data[3:0]};
                    end
                end
            end else begin
                n_out_target = TGT_ROM;
                if (has_ctrl) begin
                    n_out_addr = PHYS_ADDR_BITS'({rom_bank, r_s1_addr[13:0]}) & ROM_MASK;
                end else begin
                    // flat ROM, no banking
                    n_out_addr = PHYS_ADDR_BITS'(r_s1_addr) & ROM_MASK;
                end
            end
        end else if (in_ram && (!has_ctrl || r_ram_en)) begin
            n_out_target = TGT_RAM;
            n_out_strobe = r_s1_op;
            if (is_mbc1) begin
                n_out_addr = PHYS_ADDR_BITS'({ram_bank, r_s1_addr[12:0]});
            end else if (is_mbc2) begin
                // 512-entry internal RAM, mirrored
                n_out_addr = PHYS_ADDR_BITS'(r_s1_addr[8:0]);
            end else begin
                n_out_addr = PHYS_ADDR_BITS'(r_s1_addr[12:0]);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_MBC1;
            r_ram_en    <= 1'b0;
            r_low_bank  <= 5'd1;
            r_up_bank   <= 2'd0;
            r_mode      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= i_cfg_data;
            end
            if (s1_adv) begin
                r_s1_valid <= i_req.valid;
            end
            if (s2_adv) begin
                r_out_valid <= r_s1_valid;
                // banking state changes only when the access moves on
                if (r_s1_valid) begin
                    r_ram_en   <= n_ram_en;
                    r_low_bank <= n_low_bank;
                    r_up_bank  <= n_up_bank;
                    r_mode     <= n_mode;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_req.valid) begin
            r_s1_op   <= i_req.operation;
            r_s1_addr <= i_req.bus_address;
            r_s1_data <= i_req.write_data;
        end
        if (s2_adv && r_s1_valid) begin
            r_out_target <= n_out_target;
            r_out_addr   <= n_out_addr;
            r_out_strobe <= n_out_strobe;
        end
    end

endmodule

### rtl/core/cbm_checker.sv
`timescale 1ns / 1ps
// cbm_checker: port-level checks of the cartridge bank mapper, bound to the top level
// depends on cbm_pkg and cartridge_bank_mapper

module cbm_checker import cbm_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_target,
    input logic [PHYS_ADDR_BITS-1:0] i_phys,
    input logic                      i_strobe
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_target == TGT_NONE || i_target == TGT_CTRL) |-> i_phys == '0)
        else $error("nonzero address without ROM or RAM target");

    a_strobe_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_strobe |-> i_target == TGT_RAM)
        else $error("write strobe outside external RAM");

    // external RAM never exceeds four 8 KiB banks
    a_ram_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_target == TGT_RAM |-> i_phys[PHYS_ADDR_BITS-1:15] == '0)
        else $error("RAM address out of range");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_target    (o_rsp.target),
    .i_phys      (o_rsp.physical_address),
    .i_strobe    (o_rsp.ram_write_strobe)
);

### dv/cbm_map_checker.sv
`timescale 1ns / 1ps
// cbm_map_checker: predicts the bank mapping of each accepted access and compares results
// depends on cbm_pkg and the cbm_req_if / cbm_rsp_if channels

module cbm_map_checker import cbm_pkg::*; #(
    parameter int ROM_BITS = ROM_ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    cbm_req_if         i_req,
    cbm_rsp_if         i_rsp,
    output int         o_pending,
    output int         o_failures
);

    typedef struct packed {
        t_target                   target;
        logic [PHYS_ADDR_BITS-1:0] phys;
        logic                      strobe;
    } t_mapped_access;

    // mirror of the banking state
    logic [1:0] ctrl_kind;
    logic       ram_open;
    logic [4:0] rom_bank_low;
    logic [1:0] bank_high;
    logic       ram_banking;

    t_mapped_access expected_maps[$];
    int             failures;

    initial begin
        failures   = 0;
        o_pending  = 0;
        o_failures = 0;
    end

    // updates the banking state on control writes and returns the expected mapping
    function automatic t_mapped_access map_access(input logic is_write,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] data);
        t_mapped_access res;
        logic [31:0]    rom_mask;
        logic [31:0]    bank;
        logic           has_ctrl;
        rom_mask   = (32'd1 << ROM_BITS) - 32'd1;
        res.target = TGT_NONE;
        res.phys   = '0;
        res.strobe = 1'b0;
        has_ctrl   = (ctrl_kind == KIND_MBC1) || (ctrl_kind == KIND_MBC2);
        if (addr < 16'h8000) begin
            if (is_write) begin
                res.target = TGT_CTRL;
                if (ctrl_kind == KIND_MBC1) begin
                    if (addr < 16'h2000) begin
                        ram_open = (data[3:0] == RAM_ENABLE_KEY);
                    end else if (addr < 16'h4000) begin
                        rom_bank_low = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
                    end else if (addr < 16'h6000) begin
                        bank_high = data[1:0];
                    end else begin
                        ram_banking = data[0];
                    end
                end else if (ctrl_kind == KIND_MBC2 && addr < 16'h4000) begin
                    // address bit 8 picks RAM enable or bank select
                    if (!addr[8]) begin
                        ram_open = (data[3:0] == RAM_ENABLE_KEY);
                    end else begin
                        rom_bank_low = (data[3:0] == 4'd0) ? 5'd1 : {1'b0, data[3:0]};
                    end
                end
            end else begin
                res.target = TGT_ROM;
                if (ctrl_kind == KIND_MBC1) begin
                    if (addr < 16'h4000) begin
                        bank = ram_banking ? {25'd0, bank_high, 5'd0} : 32'd0;
                    end else begin
                        bank = {25'd0, bank_high, rom_bank_low};
                    end
                end else if (ctrl_kind == KIND_MBC2) begin
                    if (addr < 16'h4000) begin
                        bank = 32'd0;
                    end else begin
                        bank = {28'd0, rom_bank_low[3:0]};
                        if (bank == 32'd0) begin
                            bank = 32'd1;
                        end
                    end
                end
                if (has_ctrl) begin
                    res.phys = PHYS_ADDR_BITS'(((bank << 14) | (32'(addr) & 32'h3FFF))
                                               & rom_mask);
                end else begin
                    // flat ROM
                    res.phys = PHYS_ADDR_BITS'(32'(addr) & rom_mask);
                end
            end
        end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
            if (!has_ctrl || ram_open) begin
                res.target = TGT_RAM;
                res.strobe = is_write;
                if (ctrl_kind == KIND_MBC1) begin
                    bank     = ram_banking ? {30'd0, bank_high} : 32'd0;
                    res.phys = PHYS_ADDR_BITS'((bank << 13) | (32'(addr) & 32'h1FFF));
                end else if (ctrl_kind == KIND_MBC2) begin
                    res.phys = PHYS_ADDR_BITS'(32'(addr) & 32'h1FF);
                end else begin
                    res.phys = PHYS_ADDR_BITS'(32'(addr) & 32'h1FFF);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mapped_access exp_map;
        if (!i_rst_n) begin
            ctrl_kind    = KIND_MBC1;
            ram_open     = 1'b0;
            rom_bank_low = 5'd1;
            bank_high    = 2'd0;
            ram_banking  = 1'b0;
            expected_maps.delete();
        end else begin
            // results first: a result never belongs to a request of the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_maps.size() == 0) begin
                    $error("result transfer with no access outstanding");
                    failures++;
                end else begin
                    exp_map = expected_maps.pop_front();
                    if (i_rsp.target !== exp_map.target) begin
                        $error("target: expected %0d, got %0d", exp_map.target, i_rsp.target);
                        failures++;
                    end
                    if (i_rsp.physical_address !== exp_map.phys) begin
                        $error("physical_address: expected 0x%06h, got 0x%06h",
                               exp_map.phys, i_rsp.physical_address);
                        failures++;
                    end
                    if (i_rsp.ram_write_strobe !== exp_map.strobe) begin
                        $error("ram_write_strobe: expected %0d, got %0d",
                               exp_map.strobe, i_rsp.ram_write_strobe);
                        failures++;
                    end
                end
            end
            if (i_cfg_we) begin
                ctrl_kind = i_cfg_data;
            end
            if (i_req.valid && i_req.ready) begin
                expected_maps.push_back(map_access(i_req.operation, i_req.bus_address,
                                                   i_req.write_data));
            end
        end
        o_pending  <= expected_maps.size();
        o_failures <= failures;
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for cartridge_bank_mapper across all controller kinds
// depends on cbm_pkg, cbm_if, cartridge_bank_mapper and cbm_map_checker

module tb_top;
    import cbm_pkg::*;

    // kind 3 is unused and must act as no controller
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic       OP_READ     = 1'b0;
    localparam logic       OP_WRITE    = 1'b1;
    localparam int         PHASE_ITEMS = 175;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;
    int         pending;
    int         failures;

    // idling switches, changed per phase
    logic       sender_idles;
    logic       sink_stalls;
    int         stall_left;

    logic [1:0] phase_kinds[7];

    cbm_req_if req_if ();
    cbm_rsp_if rsp_if ();

    cartridge_bank_mapper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    cbm_map_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .i_rsp      (rsp_if),
        .o_pending  (pending),
        .o_failures (failures)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // every input known from time zero
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = KIND_MBC1;
        req_if.valid       = 1'b0;
        req_if.operation   = OP_READ;
        req_if.bus_address = '0;
        req_if.write_data  = '0;
        rsp_if.ready       = 1'b1;
        sender_idles       = 1'b1;
        sink_stalls        = 1'b1;
        stall_left         = 0;
    end

    // result side: ready drops for random stretches while stalls are enabled
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(1, 18) - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // one access, held until its transfer; entered and left at a falling edge
    task automatic send_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] data);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.bus_address <= addr;
        req_if.write_data  <= data;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // controller kind is only changed with the pipeline empty
    task automatic set_controller(input logic [1:0] kind);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= kind;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly mapped regions, some unmapped, some fully random addresses
    function automatic logic [15:0] pick_address();
        unique case ($urandom_range(0, 11))
            0, 1:    return 16'($urandom_range(16'h0000, 16'h3FFF));
            2, 3:    return 16'($urandom_range(16'h4000, 16'h7FFF));
            4, 5, 6: return 16'($urandom_range(16'hA000, 16'hBFFF));
            7:       return 16'($urandom_range(16'h8000, 16'h9FFF));
            8:       return 16'($urandom_range(16'hC000, 16'hFFFF));
            // control-region addresses near the MBC2 bit-8 split and the region edges
            9:       return 16'($urandom_range(0, 3)) << 13 | 16'($urandom_range(0, 1)) << 8;
            default: return 16'($urandom);
        endcase
    endfunction

    // the enable key in the low nibble often enough to keep RAM reachable
    function automatic logic [7:0] pick_data();
        logic [7:0] data;
        data = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            data[3:0] = RAM_ENABLE_KEY;
        end
        return data;
    endfunction

    initial begin
        phase_kinds = '{KIND_MBC2, KIND_NONE, KIND_UNUSED, KIND_MBC1,
                        KIND_MBC2, KIND_NONE, KIND_MBC1};

        // synchronous reset, released on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, MBC1: reset values, RAM gating, bank fields, mode, decode edges
        set_controller(KIND_MBC1);
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_READ,  16'h7FFF, 8'hFF);
        send_access(OP_READ,  16'hA000, 8'h00);   // RAM still disabled
        send_access(OP_WRITE, 16'hA000, 8'hFF);   // no strobe while disabled
        send_access(OP_WRITE, 16'h0000, 8'h0A);   // enable RAM
        send_access(OP_READ,  16'hBFFF, 8'h00);
        send_access(OP_WRITE, 16'hA123, 8'hFF);   // strobe
        send_access(OP_WRITE, 16'h2000, 8'h00);   // bank zero stored as one
        send_access(OP_READ,  16'h4000, 8'h00);
        send_access(OP_WRITE, 16'h3FFF, 8'hFF);   // low bank 0x1F
        send_access(OP_WRITE, 16'h4000, 8'h03);   // upper bits 3
        send_access(OP_READ,  16'h7FFF, 8'h00);
        send_access(OP_READ,  16'h0000, 8'h00);   // mode 0: bank 0
        send_access(OP_WRITE, 16'h6000, 8'h01);   // RAM banking mode, banks kept
        send_access(OP_READ,  16'h3FFF, 8'h00);
        send_access(OP_READ,  16'hA000, 8'h00);   // RAM bank 3
        send_access(OP_READ,  16'h8000, 8'hFF);
        send_access(OP_READ,  16'h9FFF, 8'h00);
        send_access(OP_READ,  16'hC000, 8'h00);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF);
        send_access(OP_WRITE, 16'h1FFF, 8'hFB);   // disable
        send_access(OP_READ,  16'hB000, 8'h00);
        send_access(OP_WRITE, 16'h7FFF, 8'hFE);   // back to ROM banking mode
        send_access(OP_WRITE, 16'h2000, 8'h10);   // low nibble zero, seen by MBC2 below

        // directed part, MBC2: zero bank after the switch, bit-8 decode, ignored writes
        set_controller(KIND_MBC2);
        send_access(OP_READ,  16'h4000, 8'h00);   // low nibble zero maps to bank 1
        send_access(OP_WRITE, 16'h00FF, 8'h0A);   // bit 8 clear: RAM enable
        send_access(OP_WRITE, 16'h3FFF, 8'h00);   // bit 8 set: bank zero stored as one
        send_access(OP_WRITE, 16'h4000, 8'hFF);   // ignored on MBC2
        send_access(OP_READ,  16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'hBFFF, 8'h5A);   // RAM mirrored every 512 bytes

        // random phases over every controller kind, last one without idling
        foreach (phase_kinds[p]) begin
            set_controller(phase_kinds[p]);
            sender_idles = (p % 2 == 0) && (p != 6);
            sink_stalls  = (p % 3 != 1) && (p != 6);
            repeat (PHASE_ITEMS) begin
                send_access(1'($urandom_range(0, 1)), pick_address(), pick_data());
            end
        end

        // all stimulus accepted: wait out outstanding results and the pipeline
        drain_results();
        repeat (10) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
